// ===== hdl/ards_pkg.sv =====
`default_nettype none

package ards_pkg;

    localparam logic [7:0] NAME_SEP  = 8'h3D;  // '='
    localparam logic [7:0] VALUE_SEP = 8'h3B;  // ';'

    localparam int CMD_DEPTH = 4;

    typedef enum logic [2:0] {
        KIND_NAME_BYTE  = 3'd0,
        KIND_NAME_END   = 3'd1,
        KIND_VALUE_BYTE = 3'd2,
        KIND_VALUE_END  = 3'd3,
        KIND_OK         = 3'd4,
        KIND_CORRUPT    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_NAME  = 2'd1,
        PH_VALUE = 2'd2,
        PH_SEMI  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] payload;
        logic       run_last;
    } out_item_t;

    // One decoded input byte: one to three results sharing the same byte.
    typedef struct packed {
        logic [1:0]      cnt;    // number of results, 1..3
        kind_t [2:0]     kinds;  // kinds[0] goes out first
        logic [7:0]      data_byte;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ards_stream_if.sv =====
`default_nettype none

interface ards_stream_if #(
    parameter type item_t = logic
) ();

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);

endinterface

`default_nettype wire

// ===== hdl/ards_front.sv =====
`default_nettype none

// Classifies each byte against the parse phase and emits at most one command.
module ards_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ards_pkg::in_item_t in_item,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output ards_pkg::cmd_t        push_cmd
);

    ards_pkg::phase_t phase_reg;
    ards_pkg::phase_t phase_next;
    ards_pkg::phase_t ph_body;
    logic [1:0]       n_body;
    ards_pkg::kind_t  k0;
    ards_pkg::kind_t  k1;
    ards_pkg::kind_t  k2;
    logic             fire;
    logic             is_eq;
    logic             is_semi;
    logic             last;

    assign in_ready = push_ready;
    assign fire     = in_valid && push_ready;
    assign is_eq    = (in_item.data_byte == ards_pkg::NAME_SEP);
    assign is_semi  = (in_item.data_byte == ards_pkg::VALUE_SEP);
    assign last     = in_item.end_of_buffer;

    always_comb
    begin
        ards_pkg::kind_t tail;
        n_body  = 2'd1;
        ph_body = phase_reg;
        k0      = ards_pkg::KIND_NAME_BYTE;
        k1      = ards_pkg::KIND_NAME_BYTE;
        k2      = ards_pkg::KIND_NAME_BYTE;
        case (phase_reg)
            ards_pkg::PH_FIRST:
            begin
                ph_body = ards_pkg::PH_NAME;
            end
            ards_pkg::PH_NAME:
            begin
                if (is_eq)
                begin
                    k0      = ards_pkg::KIND_NAME_END;
                    ph_body = ards_pkg::PH_VALUE;
                end
            end
            ards_pkg::PH_VALUE:
            begin
                if (is_semi)
                begin
                    if (last)
                    begin
                        k0      = ards_pkg::KIND_VALUE_END;
                        ph_body = ards_pkg::PH_FIRST;
                    end
                    else
                    begin
                        n_body  = 2'd0;  // held until the next byte
                        ph_body = ards_pkg::PH_SEMI;
                    end
                end
                else
                begin
                    k0 = ards_pkg::KIND_VALUE_BYTE;
                end
            end
            default:
            begin
                if (is_semi)
                begin
                    k0      = ards_pkg::KIND_VALUE_BYTE;
                    ph_body = ards_pkg::PH_VALUE;
                end
                else
                begin
                    k0      = ards_pkg::KIND_VALUE_END;
                    k1      = ards_pkg::KIND_NAME_BYTE;
                    n_body  = 2'd2;
                    ph_body = ards_pkg::PH_NAME;
                end
            end
        endcase

        // Buffer status goes after the body results.
        tail = (ph_body == ards_pkg::PH_FIRST) ? ards_pkg::KIND_OK
                                               : ards_pkg::KIND_CORRUPT;
        push_cmd.cnt = n_body;
        phase_next   = ph_body;
        if (last)
        begin
            push_cmd.cnt = n_body + 2'd1;
            phase_next   = ards_pkg::PH_FIRST;
            case (n_body)
                2'd0:    k0 = tail;
                2'd1:    k1 = tail;
                default: k2 = tail;
            endcase
        end
        push_cmd.kinds     = {k2, k1, k0};
        push_cmd.data_byte = in_item.data_byte;
    end

    assign push_valid = in_valid && (push_cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ards_pkg::PH_FIRST;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ards_cmd_fifo.sv =====
`default_nettype none

// Small register queue between classifier and result sequencer.
module ards_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire ards_pkg::cmd_t push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output ards_pkg::cmd_t      pop_cmd
);

    localparam int PW = $clog2(ards_pkg::CMD_DEPTH);
    localparam int CW = $clog2(ards_pkg::CMD_DEPTH + 1);

    ards_pkg::cmd_t mem_reg [ards_pkg::CMD_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(ards_pkg::CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ards_back.sv =====
`default_nettype none

// Walks each queued command one result per cycle, while the output is not stalled, into the output register.
module ards_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire ards_pkg::cmd_t pop_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ards_pkg::out_item_t out_item
);

    logic [1:0]          sub_reg;
    logic [1:0]          sub_next;
    logic                out_valid_reg;
    ards_pkg::out_item_t out_item_reg;
    ards_pkg::out_item_t out_item_next;
    ards_pkg::kind_t     cur_kind;
    logic                load;
    logic                is_final;

    assign load      = pop_valid && (!out_valid_reg || out_ready);
    assign cur_kind  = pop_cmd.kinds[sub_reg];
    assign is_final  = (sub_reg == pop_cmd.cnt - 2'd1);
    assign pop_ready = load && is_final;
    assign sub_next  = is_final ? 2'd0 : sub_reg + 2'd1;

    always_comb
    begin
        out_item_next.kind     = cur_kind;
        out_item_next.run_last = is_final;
        if ((cur_kind == ards_pkg::KIND_NAME_BYTE) ||
            (cur_kind == ards_pkg::KIND_VALUE_BYTE))
        begin
            out_item_next.payload = pop_cmd.data_byte;
        end
        else
        begin
            out_item_next.payload = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                sub_reg       <= sub_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== hdl/attr_record_stream_decoder_core.sv =====
`default_nettype none

// Path: a byte's command is registered in the queue, then each of its results in the output register.
// Throughput: one byte per cycle while each byte yields at most one result
// and the output is not stalled; the output side moves one result per cycle
// while not stalled, and extra results of bytes yielding two or three are soaked up by a 4-entry queue.
// Reset: rst_n asynchronous, active low; clears the parse phase, the queue
// and the output valid. No clearing pass, ready right out of reset.
module attr_record_stream_decoder_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ards_stream_if.sink   byte_stream,
    ards_stream_if.source event_stream
);

    // Front -> queue
    logic           push_valid;
    logic           push_ready;
    ards_pkg::cmd_t push_cmd;

    // Queue -> back
    logic           pop_valid;
    logic           pop_ready;
    ards_pkg::cmd_t pop_cmd;

    // Classifier: tracks the parse phase and turns each byte into one
    // command (0..3 results). A ';' inside a value yields no command until
    // the next byte says whether it was doubled, so nothing is queued then.
    ards_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_stream.valid),
        .in_ready   (byte_stream.ready),
        .in_item    (byte_stream.data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decoupling queue: the front stalls only when it is full.
    ards_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Result sequencer: one result per cycle, while the output is not stalled, into a registered output,
    // run_last on the last result of each byte.
    ards_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (event_stream.valid),
        .out_ready (event_stream.ready),
        .out_item  (event_stream.data)
    );

endmodule

`default_nettype wire

// ===== hdl/ards_checker.sv =====
`default_nettype none

module ards_checker (
    input wire logic     clk,
    input wire logic     rst_n,
    ards_stream_if.source event_stream
);

    // Stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_stream.valid && !event_stream.ready |=>
            event_stream.valid && $stable(event_stream.data))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        event_stream.valid |->
            (event_stream.data.kind <= ards_pkg::KIND_CORRUPT))
        else $error("result kind out of range");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        event_stream.valid &&
        (event_stream.data.kind != ards_pkg::KIND_NAME_BYTE) &&
        (event_stream.data.kind != ards_pkg::KIND_VALUE_BYTE) |->
            (event_stream.data.payload == 8'd0))
        else $error("payload not zero on a marker result");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        event_stream.valid &&
        ((event_stream.data.kind == ards_pkg::KIND_OK) ||
         (event_stream.data.kind == ards_pkg::KIND_CORRUPT)) |->
            event_stream.data.run_last)
        else $error("buffer status is not the last result of its byte");

endmodule

bind attr_record_stream_decoder_core ards_checker u_ards_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .event_stream (event_stream)
);

`default_nettype wire
